// File: hdl/skf_pkg.sv
// shared types, constants and the microcode table of the scalar kalman filter
package skf_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned StepW    = 4;

  localparam logic [DataW-1:0] ProcessNoiseRst     = 32'd655;
  localparam logic [DataW-1:0] MeasurementNoiseRst = 32'd6554;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegProcessNoise     = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMeasurementNoise = 1'b1;

  // input op codes
  localparam logic OpSample  = 1'b0;
  localparam logic OpRestart = 1'b1;

  typedef enum logic [3:0] {
    U_FETCH,
    U_PP,
    U_DEN,
    U_DIV,
    U_DIFF,
    U_MUL_EST,
    U_UPD_EST,
    U_MUL_COV,
    U_UPD_COV,
    U_EMIT,
    U_GAIN_ONE
  } uop_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_ALWAYS,
    J_DISPATCH,
    J_DEN_ZERO,
    J_LOOP,
    J_WAIT_OUT
  } jump_e;

  // program step addresses
  localparam logic [StepW-1:0] StepFetch   = 4'd0;
  localparam logic [StepW-1:0] StepPp      = 4'd1;
  localparam logic [StepW-1:0] StepDen     = 4'd2;
  localparam logic [StepW-1:0] StepDiv     = 4'd3;
  localparam logic [StepW-1:0] StepDiff    = 4'd4;
  localparam logic [StepW-1:0] StepMulEst  = 4'd5;
  localparam logic [StepW-1:0] StepUpdEst  = 4'd6;
  localparam logic [StepW-1:0] StepMulCov  = 4'd7;
  localparam logic [StepW-1:0] StepUpdCov  = 4'd8;
  localparam logic [StepW-1:0] StepEmit    = 4'd9;
  localparam logic [StepW-1:0] StepGainOne = 4'd10;

  typedef struct packed {
    uop_e             uop;
    jump_e            jmp;
    logic [StepW-1:0] target;
    logic             cnt_load;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    uop_e uop;
    logic exec;
    logic take;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic restart;
    logic primed;
    logic den_zero;
    logic out_busy;
  } status_t;

  function automatic ucode_t ucode(input logic [StepW-1:0] step);
    ucode_t cw;
    cw = '{uop: U_FETCH, jmp: J_DISPATCH, target: StepEmit, cnt_load: 1'b0};
    case (step)
      StepFetch:   cw = '{U_FETCH,    J_DISPATCH, StepEmit,  1'b0};
      StepPp:      cw = '{U_PP,       J_NEXT,     StepFetch, 1'b0};
      StepDen:     cw = '{U_DEN,      J_DEN_ZERO, StepGainOne, 1'b1};
      StepDiv:     cw = '{U_DIV,      J_LOOP,     StepDiv,   1'b0};
      StepDiff:    cw = '{U_DIFF,     J_NEXT,     StepFetch, 1'b0};
      StepMulEst:  cw = '{U_MUL_EST,  J_NEXT,     StepFetch, 1'b0};
      StepUpdEst:  cw = '{U_UPD_EST,  J_NEXT,     StepFetch, 1'b0};
      StepMulCov:  cw = '{U_MUL_COV,  J_NEXT,     StepFetch, 1'b0};
      StepUpdCov:  cw = '{U_UPD_COV,  J_NEXT,     StepFetch, 1'b0};
      StepEmit:    cw = '{U_EMIT,     J_WAIT_OUT, StepFetch, 1'b0};
      StepGainOne: cw = '{U_GAIN_ONE, J_ALWAYS,   StepDiff,  1'b0};
      default:     cw = '{U_FETCH,    J_ALWAYS,   StepFetch, 1'b0};
    endcase
    return cw;
  endfunction

endpackage

// File: hdl/skf_seq.sv
// microcode sequencer: step counter, control rom and loop counter
module skf_seq #(
  parameter int unsigned DivSteps = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  skf_pkg::status_t  status_i,
  output skf_pkg::ctrl_t    ctrl_o
);

  localparam int unsigned CntW = $clog2(DivSteps);
  localparam logic [CntW-1:0] CntLast = CntW'(DivSteps - 1);

  logic [skf_pkg::StepW-1:0] pc_q, pc_d, pc_inc;
  logic [CntW-1:0]           cnt_q, cnt_d;
  skf_pkg::ucode_t           cw;
  logic                      exec;

  assign cw     = skf_pkg::ucode(pc_q);
  assign pc_inc = pc_q + skf_pkg::StepW'(1);

  always_comb begin
    pc_d  = pc_inc;
    cnt_d = cnt_q;
    exec  = 1'b1;
    if (cw.cnt_load) begin
      cnt_d = CntLast;
    end
    case (cw.jmp)
      skf_pkg::J_NEXT: begin
        pc_d = pc_inc;
      end
      skf_pkg::J_ALWAYS: begin
        pc_d = cw.target;
      end
      skf_pkg::J_DISPATCH: begin
        exec = status_i.in_valid;
        if (!status_i.in_valid || status_i.restart) begin
          pc_d = pc_q;
        end else if (!status_i.primed) begin
          pc_d = cw.target;
        end else begin
          pc_d = pc_inc;
        end
      end
      skf_pkg::J_DEN_ZERO: begin
        pc_d = status_i.den_zero ? cw.target : pc_inc;
      end
      skf_pkg::J_LOOP: begin
        if (cnt_q != '0) begin
          pc_d  = cw.target;
          cnt_d = cnt_q - CntW'(1);
        end else begin
          pc_d = pc_inc;
        end
      end
      skf_pkg::J_WAIT_OUT: begin
        exec = !status_i.out_busy;
        pc_d = status_i.out_busy ? pc_q : cw.target;
      end
      default: begin
        pc_d = skf_pkg::StepFetch;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= skf_pkg::StepFetch;
      cnt_q <= '0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
    end
  end

  assign ctrl_o.uop  = cw.uop;
  assign ctrl_o.exec = exec;
  assign ctrl_o.take = (cw.jmp == skf_pkg::J_DISPATCH);

endmodule

// File: hdl/scalar_kalman_filter.sv
// one-dimensional kalman filter: top level with datapath, config and output register
// A sample goes from acceptance through the pp, denominator, gain divide, difference,
// estimate update, covariance update and emit steps to its result, most of the time
// spent in the restoring gain divider, which produces one quotient bit per cycle. The
// first sample after reset or restart is passed through straight to the emit step; a
// restart item gives no result. Items are taken one at a time: s_axis_tready is high
// only while the sequencer waits for input, and a finished estimate sits in an output
// register so the next item can be taken while the estimate still waits to be read.
module scalar_kalman_filter #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [skf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [skf_pkg::DataW-1:0]       cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [skf_pkg::DataW-1:0]       s_axis_tdata,   // [31:0] sample
  input  logic                            s_axis_tuser,   // [0] op
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [skf_pkg::DataW-1:0]       m_axis_tdata    // [31:0] estimate
);

  localparam int unsigned GW = FRAC_BITS + 1;
  localparam int unsigned PW = GW + 34;
  localparam logic [GW-1:0] GainOne = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [31:0]   CovOne  = 32'(GainOne);

  skf_pkg::ctrl_t   ctrl;
  skf_pkg::status_t status;

  logic [31:0]        q_q, r_q;
  logic               primed_q;
  logic signed [31:0] est_q, est_d;
  logic [31:0]        cov_q;
  logic signed [31:0] z_q;
  logic [31:0]        pp_q, pp_d;
  logic [32:0]        den_q, den_d;
  logic [33:0]        rem_q, rem_keep;
  logic [34:0]        trial;
  logic               ge;
  logic [GW-1:0]      quo_q;
  logic signed [32:0] diff_q;
  logic signed [PW-1:0] prod_q, mul_est;
  logic [GW+31:0]     mul_cov;
  logic [32:0]        cov_sum;
  logic signed [34:0] est_sum;
  logic               out_valid_q;
  logic [31:0]        out_data_q;
  logic               fire;

  skf_seq #(
    .DivSteps(GW)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .ctrl_o  (ctrl)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ctrl.take;

  assign status.in_valid = s_axis_tvalid;
  assign status.restart  = (s_axis_tuser == skf_pkg::OpRestart);
  assign status.primed   = primed_q;
  assign status.den_zero = (den_d == '0);
  assign status.out_busy = out_valid_q && !m_axis_tready;

  assign fire = ctrl.exec;

  // saturating p + q
  assign cov_sum = {1'b0, cov_q} + {1'b0, q_q};
  assign pp_d    = cov_sum[32] ? '1 : cov_sum[31:0];
  assign den_d   = {1'b0, pp_q} + {1'b0, r_q};

  // one restoring divide step
  assign trial    = {1'b0, rem_q} - {2'b00, den_q};
  assign ge       = !trial[34];
  assign rem_keep = ge ? trial[33:0] : rem_q;

  assign mul_est = $signed({1'b0, quo_q}) * diff_q;
  assign mul_cov = (GainOne - quo_q) * pp_q;

  // floor shift of the correction, then saturate to 32 bits
  assign est_sum = {{3{est_q[31]}}, est_q} + prod_q[PW-1:FRAC_BITS];
  always_comb begin
    if (!est_sum[34] && (est_sum[33:31] != 3'b000)) begin
      est_d = 32'sh7fffffff;
    end else if (est_sum[34] && (est_sum[33:31] != 3'b111)) begin
      est_d = 32'sh80000000;
    end else begin
      est_d = est_sum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q         <= skf_pkg::ProcessNoiseRst;
      r_q         <= skf_pkg::MeasurementNoiseRst;
      primed_q    <= 1'b0;
      est_q       <= '0;
      cov_q       <= CovOne;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          skf_pkg::RegProcessNoise:     q_q <= cfg_data_i;
          skf_pkg::RegMeasurementNoise: r_q <= cfg_data_i;
          default: ;
        endcase
      end
      // a new estimate wins over the read of the old one
      if (fire && (ctrl.uop == skf_pkg::U_EMIT)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        case (ctrl.uop)
          skf_pkg::U_FETCH: begin
            if (s_axis_tuser == skf_pkg::OpRestart) begin
              primed_q <= 1'b0;
              est_q    <= '0;
              cov_q    <= CovOne;
            end else if (!primed_q) begin
              primed_q <= 1'b1;
              est_q    <= s_axis_tdata;
            end
          end
          skf_pkg::U_UPD_EST: est_q       <= est_d;
          skf_pkg::U_UPD_COV: cov_q       <= prod_q[FRAC_BITS+31:FRAC_BITS];
          default: ;
        endcase
      end
    end
  end

  // datapath payload registers
  always_ff @(posedge clk_i) begin
    if (fire) begin
      case (ctrl.uop)
        skf_pkg::U_FETCH:    z_q        <= s_axis_tdata;
        skf_pkg::U_PP:       pp_q       <= pp_d;
        skf_pkg::U_DEN: begin
          den_q <= den_d;
          rem_q <= {2'b00, pp_q};
        end
        skf_pkg::U_DIV: begin
          rem_q <= {rem_keep[32:0], 1'b0};
          quo_q <= {quo_q[GW-2:0], ge};
        end
        skf_pkg::U_GAIN_ONE: quo_q      <= GainOne;
        skf_pkg::U_DIFF:     diff_q     <= {z_q[31], z_q} - {est_q[31], est_q};
        skf_pkg::U_MUL_EST:  prod_q     <= mul_est;
        skf_pkg::U_MUL_COV:  prod_q     <= $signed({2'b00, mul_cov});
        skf_pkg::U_EMIT:     out_data_q <= est_q;
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: hdl/skf_checker.sv
// port-level checks of the scalar kalman filter and their binding
module skf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [skf_pkg::CfgIdxW-1:0] cfg_index_i,
  input logic [skf_pkg::DataW-1:0]   cfg_data_i,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [skf_pkg::DataW-1:0]   s_axis_tdata,
  input logic                        s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [skf_pkg::DataW-1:0]   m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a sample transaction keeps the input closed while it is worked on
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == skf_pkg::OpSample)
    |=> !s_axis_tready)
    else $error("input open right after a sample");

  // a restart leaves the input open again in the following cycle and gives no result
  a_restart_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == skf_pkg::OpRestart)
    |=> s_axis_tready)
    else $error("restart did not return to idle");

  // a result only appears as a sample finishes
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while waiting for input");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (.*);

// File: bench/skf_estimate_checker.sv
`timescale 1ns / 1ps
// watches the config, sample and estimate channels, predicts every estimate and compares
module skf_estimate_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [skf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [skf_pkg::DataW-1:0]   cfg_data_i,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [skf_pkg::DataW-1:0]   s_tdata_i,   // [31:0] sample
  input  logic                        s_tuser_i,   // [0] op
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [skf_pkg::DataW-1:0]   m_tdata_i,   // [31:0] estimate
  output int unsigned                 mismatch_cnt_o,
  output int unsigned                 owed_cnt_o
);
  import skf_pkg::*;

  localparam logic [63:0] Unity     = 64'd1 << FRAC_BITS;
  localparam logic [63:0] CovMax    = 64'h0000_0000_FFFF_FFFF;
  localparam longint      EstMax    = 64'sd2147483647;
  localparam longint      EstMin    = -64'sd2147483648;

  logic [DataW-1:0] proc_noise = ProcessNoiseRst;
  logic [DataW-1:0] meas_noise = MeasurementNoiseRst;
  logic             primed_q   = 1'b0;
  longint           est_q      = 0;
  logic [DataW-1:0] cov_q      = Unity[DataW-1:0];
  logic [DataW-1:0] owed_estimates[$];
  int unsigned      mismatch_cnt = 0;
  int unsigned      owed_cnt     = 0;

  assign mismatch_cnt_o = mismatch_cnt;
  assign owed_cnt_o     = owed_cnt;

  task automatic advance_filter(input logic op, input logic [DataW-1:0] z,
                                output logic emits, output logic [DataW-1:0] est_out);
    logic [63:0] pp;
    logic [63:0] den;
    logic [63:0] gain;
    logic [63:0] pn;
    longint      diff;
    longint      nxt;
    emits   = 1'b0;
    est_out = '0;
    if (op == OpRestart) begin
      primed_q = 1'b0;
      est_q    = 0;
      cov_q    = Unity[DataW-1:0];
    end else if (!primed_q) begin
      // first sample after reset or restart passes straight through
      primed_q = 1'b1;
      est_q    = longint'($signed(z));
      emits    = 1'b1;
      est_out  = z;
    end else begin
      pp = {32'b0, cov_q} + {32'b0, proc_noise};
      if (pp > CovMax) pp = CovMax;
      den = pp + {32'b0, meas_noise};
      if (den == 64'd0) gain = Unity;
      else gain = (pp << FRAC_BITS) / den;
      if (gain > Unity) gain = Unity;
      diff = longint'($signed(z)) - est_q;
      // arithmetic shift rounds the correction toward minus infinity
      nxt = est_q + (($signed(gain) * diff) >>> FRAC_BITS);
      if (nxt > EstMax) nxt = EstMax;
      if (nxt < EstMin) nxt = EstMin;
      est_q = nxt;
      pn = ((Unity - gain) * pp) >> FRAC_BITS;
      if (pn > CovMax) pn = CovMax;
      cov_q   = pn[DataW-1:0];
      emits   = 1'b1;
      est_out = nxt[DataW-1:0];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic             emits;
    logic [DataW-1:0] est;
    logic [DataW-1:0] want;
    if (!rst_ni) begin
      proc_noise = ProcessNoiseRst;
      meas_noise = MeasurementNoiseRst;
      primed_q   = 1'b0;
      est_q      = 0;
      cov_q      = Unity[DataW-1:0];
      owed_estimates.delete();
      owed_cnt   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegProcessNoise:     proc_noise = cfg_data_i;
          RegMeasurementNoise: meas_noise = cfg_data_i;
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (owed_estimates.size() == 0) begin
          mismatch_cnt++;
          $error("estimate: expected none, actual %h", m_tdata_i);
        end else begin
          want = owed_estimates.pop_front();
          if (m_tdata_i !== want) begin
            mismatch_cnt++;
            $error("estimate: expected %h, actual %h", want, m_tdata_i);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        advance_filter(s_tuser_i, s_tdata_i, emits, est);
        if (emits) owed_estimates.push_back(est);
      end
      owed_cnt = unsigned'(owed_estimates.size());
    end
  end

endmodule

// File: bench/scalar_kalman_filter_tb.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, stimulus and verdict for the scalar kalman filter
module scalar_kalman_filter_tb;
  import skf_pkg::*;

  localparam int unsigned FracBits     = 16;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned Segments     = 9;
  localparam int unsigned SegItems     = 45;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [DataW-1:0]   cfg_data  = '0;
  logic               s_tvalid  = 1'b0;
  logic [DataW-1:0]   s_tdata   = '0;
  logic               s_tuser   = OpSample;
  logic               m_tready  = 1'b0;
  wire                cfg_ready;
  wire                s_tready;
  wire                m_tvalid;
  wire  [DataW-1:0]   m_tdata;
  int unsigned        mismatches;
  int unsigned        owed;

  int unsigned        src_idle_pct = 0;
  int unsigned        dst_idle_pct = 0;
  bit                 hold_req     = 1'b0;
  logic [DataW-1:0]   walk         = '0;
  int unsigned        stall_cycles = 0;

  scalar_kalman_filter #(
    .FRAC_BITS(FracBits)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata)
  );

  skf_estimate_checker #(
    .FRAC_BITS(FracBits)
  ) i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tuser_i     (s_tuser),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .mismatch_cnt_o(mismatches),
    .owed_cnt_o    (owed)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // estimate receiver: random stalls, or one long hold when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    while (stall_cycles < StallLimit) begin
      @(posedge clk);
      if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("scalar_kalman_filter test failed");
    $finish;
  end

  task automatic push_item(input logic op, input logic [DataW-1:0] smp);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= smp;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and wait for every owed estimate
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (owed == 0);
  endtask

  // a restart gives no estimate, so let the block finish it before touching registers
  task automatic settle();
    drain();
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [DataW-1:0] pick_noise();
    case ($urandom_range(9))
      0:          return '0;
      1:          return 32'hFFFF_FFFF;
      2, 3, 4, 5: return $urandom_range(0, 32'h0002_0000);
      6, 7:       return $urandom_range(0, 32'h0100_0000);
      default:    return $urandom();
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_sample();
    logic [DataW-1:0] off;
    off = $urandom_range(0, 32'h0008_0000);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return walk + off - 32'h0004_0000;
      5, 6, 7:       return $urandom();
      8: begin
        case ($urandom_range(3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default:       return $urandom_range(0, 32'h0000_FFFF);
    endcase
  endfunction

  initial begin
    logic op;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values, full-scale swings and restarts
    src_idle_pct = 15;
    dst_idle_pct = 84;
    push_item(OpSample, 32'h7FFF_FFFF);
    push_item(OpSample, 32'h8000_0000);
    push_item(OpSample, 32'h7FFF_FFFF);
    push_item(OpSample, 32'h0000_0000);
    push_item(OpRestart, 32'hFFFF_FFFF);
    push_item(OpRestart, 32'h0000_0000);
    push_item(OpSample, 32'hFFFF_FFFF);
    push_item(OpSample, 32'h0000_0001);
    push_item(OpSample, 32'h8000_0000);
    push_item(OpRestart, 32'h1234_5678);
    push_item(OpSample, 32'h0001_8000);
    settle();

    // no noise at all: gain of one, then a zero divisor
    write_reg(RegProcessNoise, 32'h0000_0000);
    write_reg(RegMeasurementNoise, 32'h0000_0000);
    push_item(OpRestart, 32'h0000_0000);
    push_item(OpSample, 32'h0003_0000);
    push_item(OpSample, 32'hFFFD_0000);
    push_item(OpSample, 32'h1234_5678);
    push_item(OpSample, 32'h8000_0000);
    settle();

    // largest noise: covariance saturates
    write_reg(RegProcessNoise, 32'hFFFF_FFFF);
    write_reg(RegMeasurementNoise, 32'hFFFF_FFFF);
    push_item(OpSample, 32'h7FFF_FFFF);
    push_item(OpSample, 32'h8000_0000);
    push_item(OpSample, 32'h7FFF_FFFF);
    push_item(OpSample, 32'h0000_0000);
    settle();
    write_reg(RegProcessNoise, 32'h0000_0000);
    write_reg(RegMeasurementNoise, 32'hFFFF_FFFF);
    push_item(OpSample, 32'h4000_0000);
    push_item(OpSample, 32'hC000_0000);

    for (int seg = 0; seg < Segments; seg++) begin
      settle();
      case (seg / 3)
        0: begin
          src_idle_pct = 15;
          dst_idle_pct = 84;
        end
        1: begin
          src_idle_pct = 84;
          dst_idle_pct = 15;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase
      write_reg(RegProcessNoise, pick_noise());
      write_reg(RegMeasurementNoise, pick_noise());
      walk = $urandom();
      // long receiver hold while samples keep coming, so the input backs up
      if (seg == 1) hold_req = 1'b1;
      for (int n = 0; n < SegItems; n++) begin
        if (seg == 4 && n == SegItems / 2) drain();
        walk = walk + $urandom_range(0, 32'h0000_2000) - 32'h0000_1000;
        op   = ($urandom_range(99) < 4) ? OpRestart : OpSample;
        push_item(op, pick_sample());
      end
    end

    settle();
    if (mismatches == 0 && owed == 0) begin
      $display("scalar_kalman_filter test passed");
    end else begin
      $display("scalar_kalman_filter test failed");
    end
    $finish;
  end

endmodule
